>>> hw/rtl/link_condition_estimator_assert.svh
// assertion macros used by the port-level checker
`ifndef LINK_CONDITION_ESTIMATOR_ASSERT_SVH
`define LINK_CONDITION_ESTIMATOR_ASSERT_SVH

// same-cycle implication, off while in reset
`define LCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lce assertion failed");

// next-cycle implication, off while in reset
`define LCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lce assertion failed");

// next-cycle implication, always checked
`define LCE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lce assertion failed");

`endif

>>> hw/rtl/lce_pkg.sv
// shared types and constants of the link condition estimator
`default_nettype none

package lce_pkg;

    localparam int RATE_W = 24;
    localparam int FRAC_W = 17;
    localparam int PCT_W = 15;
    localparam int BATT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_COST = 2'd2;

    localparam logic CMD_RADIO = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic MODE_DIRECT = 1'b0;
    localparam logic MODE_SMOOTHED = 1'b1;

    localparam logic [RATE_W-1:0] MIN_RATE = 24'd8000;
    localparam logic [RATE_W-1:0] CAP_RESET = 24'd2000000;

    localparam int SUM_WEIGHT = 40;
    localparam int LATEST_WEIGHT = 60;
    localparam int ROUND_BIAS = 128;
    localparam int PCT_SCALE = 100;
    localparam int FRAC_SHIFT = 16;

    localparam int DIV_N = 40;
    localparam int DIV_STEP_W = 6;
    localparam int DIV_REM_W = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_FRAC_GO,
        ST_FRAC_WAIT,
        ST_RING_SUB,
        ST_RING_ADD,
        ST_CHECK,
        ST_FIN_A,
        ST_FIN_B,
        ST_PCT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic clamp;
        logic frac_go;
        logic frac_zero;
        logic frac_take;
        logic ring_sub;
        logic ring_add;
        logic fin_a;
        logic fin_b;
        logic pct_direct;
        logic pct_blend;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic cap_zero;
        logic div_done;
        logic mode;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/lce_divider.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module lce_divider (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [lce_pkg::DIV_STEP_W-1:0]  i_steps,
    input  wire logic [lce_pkg::DIV_N-1:0]       i_dividend,
    input  wire logic [lce_pkg::DIV_REM_W-1:0]   i_divisor,
    output logic                                 o_done,
    output logic [lce_pkg::DIV_N-1:0]            o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [lce_pkg::DIV_STEP_W-1:0]    r_cnt;
    logic [lce_pkg::DIV_N-1:0]         r_dvd;
    logic [lce_pkg::DIV_REM_W-1:0]     r_rem;
    logic [lce_pkg::DIV_REM_W-1:0]     r_div;

    logic [lce_pkg::DIV_REM_W:0]       n_shift;
    logic [lce_pkg::DIV_REM_W:0]       n_diff;
    logic                              n_ge;

    always_comb begin
        n_shift = {r_rem, r_dvd[lce_pkg::DIV_N-1]};
        n_diff = n_shift - {1'b0, r_div};
        n_ge = (n_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == lce_pkg::DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= i_steps;
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - lce_pkg::DIV_STEP_W'(1);
            r_rem <= n_ge ? n_diff[lce_pkg::DIV_REM_W-1:0]
                          : n_shift[lce_pkg::DIV_REM_W-1:0];
            r_dvd <= {r_dvd[lce_pkg::DIV_N-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_dvd;

endmodule

`default_nettype wire

>>> hw/rtl/lce_datapath.sv
// datapath: config registers, rate state, load ring, blend arithmetic, output register
`default_nettype none

module lce_datapath #(
    parameter int HISTORY_DEPTH = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lce_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_command,
    input  wire logic [lce_pkg::RATE_W-1:0]      i_rate_value,
    input  wire logic                            i_out_stall,
    input  wire lce_pkg::t_dp_cmd                i_cmd,
    output lce_pkg::t_dp_stat                    o_stat,
    output logic                                 o_out_valid,
    output logic [lce_pkg::PCT_W-1:0]            o_net_load_pct,
    output logic [lce_pkg::RATE_W-1:0]           o_transfer_rate,
    output logic [lce_pkg::BATT_W-1:0]           o_battery_level
);

    localparam int D = HISTORY_DEPTH;
    localparam int IDX_W = (D > 1) ? $clog2(D) : 1;
    localparam int SUM_W = $clog2(D * 65536 + 1);
    localparam int NUM_W = $clog2(lce_pkg::PCT_SCALE * D * 65536 + lce_pkg::ROUND_BIAS * D + 1);
    localparam int Q_W = NUM_W - 8;
    localparam int ACC_BIAS = lce_pkg::ROUND_BIAS * D;
    localparam int L_WEIGHT = lce_pkg::LATEST_WEIGHT * D;
    localparam int REC_K = Q_W + $clog2(D);
    localparam int REC_M = (2 ** REC_K + D - 1) / D;
    localparam int PROD_W = Q_W + REC_K + 1;

    logic [lce_pkg::RATE_W-1:0]  r_cap;
    logic                        r_mode;
    logic [lce_pkg::BATT_W-1:0]  r_batt;

    logic                        r_cmd;
    logic [lce_pkg::RATE_W-1:0]  r_rate;
    logic [lce_pkg::RATE_W-1:0]  r_cell;
    logic [lce_pkg::RATE_W-1:0]  r_radio;
    logic [lce_pkg::FRAC_W-1:0]  r_latest;
    logic [lce_pkg::FRAC_W-1:0]  r_ring [D];
    logic [IDX_W-1:0]            r_idx;
    logic [SUM_W-1:0]            r_sum;
    logic [NUM_W-1:0]            r_acc;
    logic [lce_pkg::RATE_W-1:0]  r_xfer;
    logic [lce_pkg::PCT_W-1:0]   r_pct;

    logic                        r_out_valid;
    logic [lce_pkg::PCT_W-1:0]   r_out_pct;
    logic [lce_pkg::RATE_W-1:0]  r_out_xfer;
    logic [lce_pkg::BATT_W-1:0]  r_out_batt;

    logic [lce_pkg::RATE_W-1:0]     n_low;
    logic [lce_pkg::RATE_W-1:0]     n_direct;
    logic [PROD_W-1:0]              n_blend;
    logic                           div_start;
    logic [lce_pkg::DIV_STEP_W-1:0] div_steps;
    logic [lce_pkg::DIV_N-1:0]      div_dividend;
    logic [lce_pkg::DIV_REM_W-1:0]  div_divisor;
    logic                           div_done;
    logic [lce_pkg::DIV_N-1:0]      div_quot;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lce_pkg::CAP_RESET;
            r_mode <= lce_pkg::MODE_DIRECT;
            r_batt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lce_pkg::CFG_LINK_CAPACITY: r_cap <= i_cfg_wdata;
                lce_pkg::CFG_LOAD_MODE:     r_mode <= i_cfg_wdata[0];
                lce_pkg::CFG_BATTERY_COST:  r_batt <= i_cfg_wdata[lce_pkg::BATT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_low = (r_cell < r_radio) ? r_cell : r_radio;
        if (n_low < lce_pkg::MIN_RATE) begin
            n_low = lce_pkg::MIN_RATE;
        end
        n_direct = lce_pkg::RATE_W'(r_latest) * lce_pkg::RATE_W'(lce_pkg::PCT_SCALE)
                 + lce_pkg::RATE_W'(lce_pkg::ROUND_BIAS);
        // blend over 256 * depth: drop 8 bits, then reciprocal multiply by depth
        n_blend = PROD_W'(r_acc[NUM_W-1:8]) * PROD_W'(REC_M);
    end

    // serial divider for the load fraction
    always_comb begin
        div_start = i_cmd.frac_go;
        div_steps = lce_pkg::DIV_STEP_W'(lce_pkg::DIV_N);
        div_dividend = {r_cell, {lce_pkg::FRAC_SHIFT{1'b0}}};
        div_divisor = r_cap;
    end

    lce_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // item state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
            r_radio <= '0;
            r_latest <= '0;
            r_idx <= '0;
            r_sum <= '0;
            for (int i = 0; i < D; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (i_cmd.clamp) begin
                if (r_cmd == lce_pkg::CMD_LOAD) begin
                    r_cell <= (r_rate < r_cap) ? r_rate : r_cap;
                end else begin
                    r_radio <= r_rate;
                end
            end
            if (i_cmd.frac_zero) begin
                r_latest <= '0;
            end else if (i_cmd.frac_take) begin
                r_latest <= div_quot[lce_pkg::FRAC_W-1:0];
            end
            if (i_cmd.ring_sub) begin
                r_sum <= r_sum - SUM_W'(r_ring[r_idx]);
                r_ring[r_idx] <= r_latest;
            end
            if (i_cmd.ring_add) begin
                r_sum <= r_sum + SUM_W'(r_latest);
                r_idx <= (r_idx == IDX_W'(D - 1)) ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_rate <= i_rate_value;
        end
        if (i_cmd.fin_a) begin
            r_xfer <= n_low;
            r_acc <= NUM_W'(r_sum) * NUM_W'(lce_pkg::SUM_WEIGHT) + NUM_W'(ACC_BIAS);
        end
        if (i_cmd.fin_b) begin
            r_xfer <= (r_xfer < r_cap) ? r_xfer : r_cap;
            r_acc <= r_acc + NUM_W'(r_latest) * NUM_W'(L_WEIGHT);
        end
        if (i_cmd.pct_direct) begin
            r_pct <= n_direct[lce_pkg::PCT_W+7:8];
        end else if (i_cmd.pct_blend) begin
            r_pct <= n_blend[REC_K +: lce_pkg::PCT_W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pct <= r_pct;
            r_out_xfer <= r_xfer;
            r_out_batt <= r_batt;
        end
    end

    always_comb begin
        o_stat.is_load = (r_cmd == lce_pkg::CMD_LOAD);
        o_stat.cap_zero = (r_cap == '0);
        o_stat.div_done = div_done;
        o_stat.mode = r_mode;
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_net_load_pct = r_out_pct;
    assign o_transfer_rate = r_out_xfer;
    assign o_battery_level = r_out_batt;

endmodule

`default_nettype wire

>>> hw/rtl/lce_ctrl.sv
// controller state machine sequencing one update at a time
`default_nettype none

module lce_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire lce_pkg::t_dp_stat   i_stat,
    output logic                     o_in_stall,
    output lce_pkg::t_dp_cmd         o_cmd
);

    lce_pkg::t_state r_state;
    lce_pkg::t_state n_state;
    logic            r_primed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lce_pkg::ST_IDLE;
            r_primed <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lce_pkg::ST_CHECK) begin
                r_primed <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lce_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lce_pkg::ST_CLAMP;
                end
            end
            lce_pkg::ST_CLAMP: begin
                n_state = i_stat.is_load ? lce_pkg::ST_FRAC_GO : lce_pkg::ST_CHECK;
            end
            lce_pkg::ST_FRAC_GO: begin
                n_state = i_stat.cap_zero ? lce_pkg::ST_RING_SUB : lce_pkg::ST_FRAC_WAIT;
            end
            lce_pkg::ST_FRAC_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = lce_pkg::ST_RING_SUB;
                end
            end
            lce_pkg::ST_RING_SUB: n_state = lce_pkg::ST_RING_ADD;
            lce_pkg::ST_RING_ADD: n_state = lce_pkg::ST_CHECK;
            lce_pkg::ST_CHECK: begin
                n_state = r_primed ? lce_pkg::ST_FIN_A : lce_pkg::ST_IDLE;
            end
            lce_pkg::ST_FIN_A: n_state = lce_pkg::ST_FIN_B;
            lce_pkg::ST_FIN_B: n_state = lce_pkg::ST_PCT;
            lce_pkg::ST_PCT: n_state = lce_pkg::ST_EMIT;
            lce_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = lce_pkg::ST_IDLE;
                end
            end
            default: n_state = lce_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            lce_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            lce_pkg::ST_CLAMP: o_cmd.clamp = 1'b1;
            lce_pkg::ST_FRAC_GO: begin
                o_cmd.frac_go = !i_stat.cap_zero;
                o_cmd.frac_zero = i_stat.cap_zero;
            end
            lce_pkg::ST_FRAC_WAIT: o_cmd.frac_take = i_stat.div_done;
            lce_pkg::ST_RING_SUB: o_cmd.ring_sub = 1'b1;
            lce_pkg::ST_RING_ADD: o_cmd.ring_add = 1'b1;
            lce_pkg::ST_CHECK: begin
            end
            lce_pkg::ST_FIN_A: o_cmd.fin_a = 1'b1;
            lce_pkg::ST_FIN_B: o_cmd.fin_b = 1'b1;
            lce_pkg::ST_PCT: begin
                o_cmd.pct_direct = (i_stat.mode == lce_pkg::MODE_DIRECT);
                o_cmd.pct_blend = (i_stat.mode == lce_pkg::MODE_SMOOTHED);
            end
            lce_pkg::ST_EMIT: o_cmd.emit = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/link_condition_estimator.sv
// top level of the link condition estimator
// radio update: capture, clamp, check, finish steps A and B, percentage, then emit to the output register
// load update: adds the load fraction from the 40-step serial divider and the ring update
// zero capacity skips the divider and takes a zero fraction; smoothed and direct mode take the same time
// one item at a time; the output register lets the next input beat in while a result waits
// synchronous active-low reset clears controller and item state, ring and config to reset values
`default_nettype none

module link_condition_estimator #(
    parameter int HISTORY_DEPTH = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lce_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_command,
    input  wire logic [lce_pkg::RATE_W-1:0]      i_rate_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [lce_pkg::PCT_W-1:0]            o_net_load_pct,
    output logic [lce_pkg::RATE_W-1:0]           o_transfer_rate,
    output logic [lce_pkg::BATT_W-1:0]           o_battery_level
);

    lce_pkg::t_dp_cmd  dp_cmd;
    lce_pkg::t_dp_stat dp_stat;

    lce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    lce_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_rate_value    (i_rate_value),
        .i_out_stall     (i_out_stall),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_out_valid     (o_out_valid),
        .o_net_load_pct  (o_net_load_pct),
        .o_transfer_rate (o_transfer_rate),
        .o_battery_level (o_battery_level)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lce_checker.sv
// port-level checker for the link condition estimator and its bind
`default_nettype none

`include "link_condition_estimator_assert.svh"

module lce_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [lce_pkg::PCT_W-1:0]   o_net_load_pct,
    input wire logic [lce_pkg::RATE_W-1:0]  o_transfer_rate,
    input wire logic [lce_pkg::BATT_W-1:0]  o_battery_level
);

    // stalled result beat holds
    `LCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_net_load_pct) && $stable(o_transfer_rate) && $stable(o_battery_level))

    `LCE_ASSERT_NOW(a_pct_range, i_clk, i_rst_n, o_out_valid, o_net_load_pct <= 15'd25600)

    // an accepted beat makes the block busy in the next cycle
    `LCE_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    `LCE_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind link_condition_estimator lce_checker u_lce_checker (.*);

`default_nettype wire
